@@ hw/rtl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// shared commands, defaults and the tag that rides with each item
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int DEFAULT_PART_WIDTH = 16;
   localparam int DEFAULT_FRAC_BITS  = 8;

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_MAG = 3'd4,
      CMD_MAX = 3'd5
   } cau_cmd_type;

   // per-item control that travels down the cell chain
   typedef struct packed {
      cau_cmd_type cmd;
      logic        gt;
      logic        eq;
      logic        sat;
      logic        dz;
   } cau_tag_type;

endpackage

@@ hw/rtl/cau_front.sv @@
// ----------------------------------------------------------------------------
// cau_front
// product stage and combine stage ahead of the divide/root cell chain
// ----------------------------------------------------------------------------
module cau_front #(
   parameter int PART_WIDTH = cau_pkg::DEFAULT_PART_WIDTH,
   parameter int FRAC_BITS  = cau_pkg::DEFAULT_FRAC_BITS,
   parameter int DIV_BITS   = 2 * PART_WIDTH + 1 + FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic                               adv1,
   input  logic                               adv2,
   input  logic [2:0]                         in_cmd,
   input  logic signed [PART_WIDTH-1:0]       in_a_re,
   input  logic signed [PART_WIDTH-1:0]       in_a_im,
   input  logic signed [PART_WIDTH-1:0]       in_b_re,
   input  logic signed [PART_WIDTH-1:0]       in_b_im,
   output logic                               mid_valid,
   output logic                               out_valid,
   output cau_pkg::cau_tag_type               out_tag,
   output logic [PART_WIDTH-1:0]              out_simp_re,
   output logic [PART_WIDTH-1:0]              out_simp_im,
   output logic [2*PART_WIDTH:0]              out_den,
   output logic [1:0][DIV_BITS-1:0]           out_num,
   output logic [1:0]                         out_neg,
   output logic [2*PART_WIDTH+1:0]            out_rad
);

   localparam int W   = PART_WIDTH;
   localparam int SW  = 2 * W + 1;
   localparam int DW  = 2 * W + 1;
   localparam int SQW = 2 * W + 2;
   localparam logic signed [SW-1:0] SMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [SW-1:0] SMIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

   function automatic logic [W:0] clip_part(input logic signed [SW-1:0] v);
      logic [W:0] r;
      if (v > SMAX) begin
         r = {1'b1, SMAX[W-1:0]};
      end else if (v < SMIN) begin
         r = {1'b1, SMIN[W-1:0]};
      end else begin
         r = {1'b0, v[W-1:0]};
      end
      return r;
   endfunction

   // stage 1: operands and products
   logic                           v1_ff;
   cau_pkg::cau_cmd_type           cmd1_ff;
   logic signed [W-1:0]            ar1_ff, ai1_ff, br1_ff, bi1_ff;
   logic signed [2*W-1:0]          p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff;
   logic signed [2*W-1:0]          p_aa_ff, p_ai_ff, p_bb_ff, p_bi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv1) begin
         v1_ff <= in_valid;
      end
      if (adv1) begin
         cmd1_ff <= cau_pkg::cau_cmd_type'(in_cmd);
         ar1_ff  <= in_a_re;
         ai1_ff  <= in_a_im;
         br1_ff  <= in_b_re;
         bi1_ff  <= in_b_im;
         p_rr_ff <= in_a_re * in_b_re;
         p_ii_ff <= in_a_im * in_b_im;
         p_ir_ff <= in_a_im * in_b_re;
         p_ri_ff <= in_a_re * in_b_im;
         p_aa_ff <= in_a_re * in_a_re;
         p_ai_ff <= in_a_im * in_a_im;
         p_bb_ff <= in_b_re * in_b_re;
         p_bi_ff <= in_b_im * in_b_im;
      end
   end

   // stage 2: sums, compares, the simple results and the divide and root inputs
   logic signed [SW-1:0]  add_re, add_im, sub_re, sub_im, mul_re, mul_im;
   logic signed [SW-1:0]  num_re, num_im;
   logic [SW-1:0]         mag_re, mag_im;
   logic [DW-1:0]         ma, mb;
   logic [W:0]            c_re, c_im;
   cau_pkg::cau_tag_type  tag_in;
   logic [W-1:0]          simp_re_in, simp_im_in;

   always_comb begin
      add_re = SW'(ar1_ff) + SW'(br1_ff);
      add_im = SW'(ai1_ff) + SW'(bi1_ff);
      sub_re = SW'(ar1_ff) - SW'(br1_ff);
      sub_im = SW'(ai1_ff) - SW'(bi1_ff);
      mul_re = (SW'(p_rr_ff) - SW'(p_ii_ff)) >>> FRAC_BITS;
      mul_im = (SW'(p_ir_ff) + SW'(p_ri_ff)) >>> FRAC_BITS;
      num_re = SW'(p_rr_ff) + SW'(p_ii_ff);
      num_im = SW'(p_ir_ff) - SW'(p_ri_ff);
      mag_re = num_re[SW-1] ? SW'(-num_re) : SW'(num_re);
      mag_im = num_im[SW-1] ? SW'(-num_im) : SW'(num_im);
      ma = DW'($unsigned(p_aa_ff)) + DW'($unsigned(p_ai_ff));
      mb = DW'($unsigned(p_bb_ff)) + DW'($unsigned(p_bi_ff));
      c_re = '0;
      c_im = '0;
      tag_in = '{cmd: cmd1_ff, gt: 1'b0, eq: 1'b0, sat: 1'b0, dz: 1'b0};
      simp_re_in = '0;
      simp_im_in = '0;
      case (cmd1_ff)
         cau_pkg::CMD_ADD: begin
            c_re = clip_part(add_re);
            c_im = clip_part(add_im);
            simp_re_in = c_re[W-1:0];
            simp_im_in = c_im[W-1:0];
            tag_in.sat = c_re[W] | c_im[W];
         end
         cau_pkg::CMD_SUB: begin
            c_re = clip_part(sub_re);
            c_im = clip_part(sub_im);
            simp_re_in = c_re[W-1:0];
            simp_im_in = c_im[W-1:0];
            tag_in.sat = c_re[W] | c_im[W];
         end
         cau_pkg::CMD_MUL: begin
            c_re = clip_part(mul_re);
            c_im = clip_part(mul_im);
            simp_re_in = c_re[W-1:0];
            simp_im_in = c_im[W-1:0];
            tag_in.sat = c_re[W] | c_im[W];
         end
         cau_pkg::CMD_DIV: begin
            tag_in.dz = (mb == '0);
         end
         cau_pkg::CMD_MAX: begin
            tag_in.gt = ma > mb;
            tag_in.eq = ma == mb;
            simp_re_in = (ma >= mb) ? ar1_ff : br1_ff;
            simp_im_in = (ma >= mb) ? ai1_ff : bi1_ff;
         end
         default: begin
         end
      endcase
   end

   logic                  v2_ff;
   cau_pkg::cau_tag_type  tag_ff;
   logic [W-1:0]          simp_re_ff, simp_im_ff;
   logic [DW-1:0]         den_ff;
   logic [1:0][DIV_BITS-1:0] num_ff;
   logic [1:0]            neg_ff;
   logic [SQW-1:0]        rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv2) begin
         v2_ff <= v1_ff;
      end
      if (adv2) begin
         tag_ff     <= tag_in;
         simp_re_ff <= simp_re_in;
         simp_im_ff <= simp_im_in;
         den_ff     <= mb;
         num_ff[0]  <= DIV_BITS'(mag_re) << FRAC_BITS;
         num_ff[1]  <= DIV_BITS'(mag_im) << FRAC_BITS;
         neg_ff     <= {num_im[SW-1], num_re[SW-1]};
         rad_ff     <= SQW'(ma);
      end
   end

   assign mid_valid   = v1_ff;
   assign out_valid   = v2_ff;
   assign out_tag     = tag_ff;
   assign out_simp_re = simp_re_ff;
   assign out_simp_im = simp_im_ff;
   assign out_den     = den_ff;
   assign out_num     = num_ff;
   assign out_neg     = neg_ff;
   assign out_rad     = rad_ff;

endmodule

@@ hw/rtl/cau_cell.sv @@
// ----------------------------------------------------------------------------
// cau_cell
// one step of the two-lane restoring divide and, optionally, of the root
// ----------------------------------------------------------------------------
module cau_cell #(
   parameter int PART_WIDTH = cau_pkg::DEFAULT_PART_WIDTH,
   parameter int DIV_BITS   = 2 * PART_WIDTH + 1 + cau_pkg::DEFAULT_FRAC_BITS,
   parameter bit SQRT_STEP  = 1'b1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  cau_pkg::cau_tag_type          in_tag,
   input  logic [PART_WIDTH-1:0]         in_simp_re,
   input  logic [PART_WIDTH-1:0]         in_simp_im,
   input  logic [2*PART_WIDTH:0]         in_den,
   input  logic [1:0][DIV_BITS-1:0]      in_num,
   input  logic [1:0]                    in_neg,
   input  logic [1:0][2*PART_WIDTH:0]    in_rem,
   input  logic [1:0][PART_WIDTH:0]      in_quo,
   input  logic [1:0]                    in_ovf,
   input  logic [2*PART_WIDTH+1:0]       in_rad,
   input  logic [PART_WIDTH:0]           in_root,
   input  logic [PART_WIDTH+1:0]         in_srem,
   output logic                          out_valid,
   output cau_pkg::cau_tag_type          out_tag,
   output logic [PART_WIDTH-1:0]         out_simp_re,
   output logic [PART_WIDTH-1:0]         out_simp_im,
   output logic [2*PART_WIDTH:0]         out_den,
   output logic [1:0][DIV_BITS-1:0]      out_num,
   output logic [1:0]                    out_neg,
   output logic [1:0][2*PART_WIDTH:0]    out_rem,
   output logic [1:0][PART_WIDTH:0]      out_quo,
   output logic [1:0]                    out_ovf,
   output logic [2*PART_WIDTH+1:0]       out_rad,
   output logic [PART_WIDTH:0]           out_root,
   output logic [PART_WIDTH+1:0]         out_srem
);

   localparam int W   = PART_WIDTH;
   localparam int DW  = 2 * W + 1;
   localparam int QW  = W + 1;
   localparam int SQW = 2 * W + 2;
   localparam int SRW = W + 2;

   logic [1:0][DW:0]       r2;
   logic [1:0][DW-1:0]     rem_in;
   logic [1:0][QW-1:0]     quo_in;
   logic [1:0]             ovf_in;
   logic [1:0][DIV_BITS-1:0] num_in;
   logic [SQW-1:0]         rad_in;
   logic [QW-1:0]          root_in;
   logic [SRW-1:0]         srem_in;

   // divide step, both lanes
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         r2[l] = {in_rem[l], in_num[l][DIV_BITS-1]};
         if (r2[l] >= {1'b0, in_den}) begin
            rem_in[l] = DW'(r2[l] - {1'b0, in_den});
            quo_in[l] = {in_quo[l][QW-2:0], 1'b1};
         end else begin
            rem_in[l] = r2[l][DW-1:0];
            quo_in[l] = {in_quo[l][QW-2:0], 1'b0};
         end
         ovf_in[l] = in_ovf[l] | in_quo[l][QW-1];
         num_in[l] = {in_num[l][DIV_BITS-2:0], 1'b0};
      end
   end

   // root step, two radicand bits per cell
   if (SQRT_STEP) begin : g_root
      logic [SRW+1:0] r4;
      logic [SRW+1:0] trial;
      always_comb begin
         r4    = {in_srem, in_rad[SQW-1:SQW-2]};
         trial = (SRW+2)'({in_root, 2'b01});
         if (r4 >= trial) begin
            srem_in = SRW'(r4 - trial);
            root_in = {in_root[QW-2:0], 1'b1};
         end else begin
            srem_in = r4[SRW-1:0];
            root_in = {in_root[QW-2:0], 1'b0};
         end
         rad_in = {in_rad[SQW-3:0], 2'b00};
      end
   end else begin : g_pass
      assign srem_in = in_srem;
      assign root_in = in_root;
      assign rad_in  = in_rad;
   end

   logic                       valid_ff;
   cau_pkg::cau_tag_type       tag_ff;
   logic [W-1:0]               simp_re_ff, simp_im_ff;
   logic [DW-1:0]              den_ff;
   logic [1:0][DIV_BITS-1:0]   num_ff;
   logic [1:0]                 neg_ff;
   logic [1:0][DW-1:0]         rem_ff;
   logic [1:0][QW-1:0]         quo_ff;
   logic [1:0]                 ovf_ff;
   logic [SQW-1:0]             rad_ff;
   logic [QW-1:0]              root_ff;
   logic [SRW-1:0]             srem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         tag_ff     <= in_tag;
         simp_re_ff <= in_simp_re;
         simp_im_ff <= in_simp_im;
         den_ff     <= in_den;
         num_ff     <= num_in;
         neg_ff     <= in_neg;
         rem_ff     <= rem_in;
         quo_ff     <= quo_in;
         ovf_ff     <= ovf_in;
         rad_ff     <= rad_in;
         root_ff    <= root_in;
         srem_ff    <= srem_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_tag     = tag_ff;
   assign out_simp_re = simp_re_ff;
   assign out_simp_im = simp_im_ff;
   assign out_den     = den_ff;
   assign out_num     = num_ff;
   assign out_neg     = neg_ff;
   assign out_rem     = rem_ff;
   assign out_quo     = quo_ff;
   assign out_ovf     = ovf_ff;
   assign out_rad     = rad_ff;
   assign out_root    = root_ff;
   assign out_srem    = srem_ff;

endmodule

@@ hw/rtl/complex_arith_unit.sv @@
// ----------------------------------------------------------------------------
// complex_arith_unit
// complex-number alu on signed fixed-point parts
// ----------------------------------------------------------------------------
// usage
//   req_ channel carries a command and two complex operands a and b; one
//   transfer on the rsp_ channel returns the result and its flags
//   commands: add, subtract, multiply, divide, magnitude of a, larger magnitude
//   a new request can be taken every cycle while req_ready is high; items leave in order
//   depth is set by the divide chain: one quotient bit per cell; the root
//   rides the first cells
//   stages: operand products, combine, cell chain, output register
//   when the receiver stalls, each stage still fills its own empty slot, so
//   bubbles close up and requests keep being taken until the chain is full
//   reset empties every stage; items in flight are dropped, none is held across it
//   divide by zero returns zero with div_zero set; clipped parts set saturated
// ----------------------------------------------------------------------------
module complex_arith_unit #(
   parameter int PART_WIDTH = cau_pkg::DEFAULT_PART_WIDTH,
   parameter int FRAC_BITS  = cau_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_command,
   input  logic signed [PART_WIDTH-1:0]  req_a_re,
   input  logic signed [PART_WIDTH-1:0]  req_a_im,
   input  logic signed [PART_WIDTH-1:0]  req_b_re,
   input  logic signed [PART_WIDTH-1:0]  req_b_im,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [PART_WIDTH-1:0]  rsp_res_re,
   output logic signed [PART_WIDTH-1:0]  rsp_res_im,
   output logic                          rsp_a_greater,
   output logic                          rsp_mag_equal,
   output logic                          rsp_saturated,
   output logic                          rsp_div_zero
);

   localparam int W        = PART_WIDTH;
   localparam int DW       = 2 * W + 1;
   localparam int QW       = W + 1;
   localparam int SQW      = 2 * W + 2;
   localparam int SRW      = W + 2;
   localparam int DIV_BITS = 2 * W + 1 + FRAC_BITS;
   localparam int NC       = DIV_BITS;   // one cell per quotient bit
   localparam int SQ_STEPS = W + 1;      // root steps, in the first cells
   localparam logic [QW-1:0] QMAX = {2'b00, {(W-1){1'b1}}};
   localparam logic [QW-1:0] QMIN = {2'b01, {(W-1){1'b0}}};

   // chain wires: index 0 is the front end, index k+1 is cell k
   logic [NC:0]                  ch_vld;
   cau_pkg::cau_tag_type         ch_tag     [NC+1];
   logic [W-1:0]                 ch_simp_re [NC+1];
   logic [W-1:0]                 ch_simp_im [NC+1];
   logic [DW-1:0]                ch_den     [NC+1];
   logic [1:0][DIV_BITS-1:0]     ch_num     [NC+1];
   logic [1:0]                   ch_neg     [NC+1];
   logic [1:0][DW-1:0]           ch_rem     [NC+1];
   logic [1:0][QW-1:0]           ch_quo     [NC+1];
   logic [1:0]                   ch_ovf     [NC+1];
   logic [SQW-1:0]               ch_rad     [NC+1];
   logic [QW-1:0]                ch_root    [NC+1];
   logic [SRW-1:0]               ch_srem    [NC+1];

   logic [NC-1:0]                cell_adv;
   logic                         out_adv, adv1, adv2, mid_valid;
   logic                         rsp_valid_ff;

   // a stage moves when it is empty or the stage after it moves
   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign adv2      = !ch_vld[0] || cell_adv[0];
   assign adv1      = !mid_valid || adv2;
   assign req_ready = adv1;

   cau_front #(
      .PART_WIDTH (PART_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .DIV_BITS   (DIV_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .adv1        (adv1),
      .adv2        (adv2),
      .in_cmd      (req_command),
      .in_a_re     (req_a_re),
      .in_a_im     (req_a_im),
      .in_b_re     (req_b_re),
      .in_b_im     (req_b_im),
      .mid_valid   (mid_valid),
      .out_valid   (ch_vld[0]),
      .out_tag     (ch_tag[0]),
      .out_simp_re (ch_simp_re[0]),
      .out_simp_im (ch_simp_im[0]),
      .out_den     (ch_den[0]),
      .out_num     (ch_num[0]),
      .out_neg     (ch_neg[0]),
      .out_rad     (ch_rad[0])
   );

   // divider remainders, quotients and root state start from zero
   assign ch_rem[0]  = '0;
   assign ch_quo[0]  = '0;
   assign ch_ovf[0]  = '0;
   assign ch_root[0] = '0;
   assign ch_srem[0] = '0;

   for (genvar k = 0; k < NC; k++) begin : g_cell
      if (k == NC - 1) begin : g_last
         assign cell_adv[k] = !ch_vld[k+1] || out_adv;
      end else begin : g_mid
         assign cell_adv[k] = !ch_vld[k+1] || cell_adv[k+1];
      end

      cau_cell #(
         .PART_WIDTH (PART_WIDTH),
         .DIV_BITS   (DIV_BITS),
         .SQRT_STEP  ((k < SQ_STEPS) ? 1'b1 : 1'b0)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .adv         (cell_adv[k]),
         .in_valid    (ch_vld[k]),
         .in_tag      (ch_tag[k]),
         .in_simp_re  (ch_simp_re[k]),
         .in_simp_im  (ch_simp_im[k]),
         .in_den      (ch_den[k]),
         .in_num      (ch_num[k]),
         .in_neg      (ch_neg[k]),
         .in_rem      (ch_rem[k]),
         .in_quo      (ch_quo[k]),
         .in_ovf      (ch_ovf[k]),
         .in_rad      (ch_rad[k]),
         .in_root     (ch_root[k]),
         .in_srem     (ch_srem[k]),
         .out_valid   (ch_vld[k+1]),
         .out_tag     (ch_tag[k+1]),
         .out_simp_re (ch_simp_re[k+1]),
         .out_simp_im (ch_simp_im[k+1]),
         .out_den     (ch_den[k+1]),
         .out_num     (ch_num[k+1]),
         .out_neg     (ch_neg[k+1]),
         .out_rem     (ch_rem[k+1]),
         .out_quo     (ch_quo[k+1]),
         .out_ovf     (ch_ovf[k+1]),
         .out_rad     (ch_rad[k+1]),
         .out_root    (ch_root[k+1]),
         .out_srem    (ch_srem[k+1])
      );
   end

   // result select and clipping at the end of the chain
   cau_pkg::cau_tag_type  tail;
   logic [1:0][W-1:0]     dq;
   logic [1:0]            dsat;
   logic [W-1:0]          re_in, im_in;
   logic                  gt_in, eq_in, sat_in, dz_in;

   always_comb begin
      tail = ch_tag[NC];
      for (int l = 0; l < 2; l++) begin
         if (!ch_neg[NC][l]) begin
            dsat[l] = ch_ovf[NC][l] || (ch_quo[NC][l] > QMAX);
            dq[l]   = dsat[l] ? QMAX[W-1:0] : ch_quo[NC][l][W-1:0];
         end else begin
            dsat[l] = ch_ovf[NC][l] || (ch_quo[NC][l] > QMIN);
            dq[l]   = dsat[l] ? QMIN[W-1:0] : W'(-ch_quo[NC][l]);
         end
      end
      re_in  = ch_simp_re[NC];
      im_in  = ch_simp_im[NC];
      gt_in  = tail.gt;
      eq_in  = tail.eq;
      sat_in = tail.sat;
      dz_in  = 1'b0;
      case (tail.cmd)
         cau_pkg::CMD_DIV: begin
            if (tail.dz) begin
               re_in  = '0;
               im_in  = '0;
               sat_in = 1'b0;
               dz_in  = 1'b1;
            end else begin
               re_in  = dq[0];
               im_in  = dq[1];
               sat_in = dsat[0] | dsat[1];
            end
         end
         cau_pkg::CMD_MAG: begin
            sat_in = ch_root[NC] > QMAX;
            re_in  = sat_in ? QMAX[W-1:0] : ch_root[NC][W-1:0];
            im_in  = '0;
         end
         default: begin
         end
      endcase
   end

   // output register parts the chain from the receiver
   logic [W-1:0] res_re_ff, res_im_ff;
   logic         gt_ff, eq_ff, sat_ff, dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= ch_vld[NC];
      end
      if (out_adv) begin
         res_re_ff <= re_in;
         res_im_ff <= im_in;
         gt_ff     <= gt_in;
         eq_ff     <= eq_in;
         sat_ff    <= sat_in;
         dz_ff     <= dz_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_res_re    = res_re_ff;
   assign rsp_res_im    = res_im_ff;
   assign rsp_a_greater = gt_ff;
   assign rsp_mag_equal = eq_ff;
   assign rsp_saturated = sat_ff;
   assign rsp_div_zero  = dz_ff;

   // checks
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && dz_ff |-> res_re_ff == '0 && res_im_ff == '0 && !sat_ff)
      else $error("divide by zero result not cleared");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(gt_ff && eq_ff))
      else $error("greater and equal both set");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request stalled with output empty");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result valid right after reset");

endmodule
